// ----- hw/rtl/nnsl_pkg.sv -----
// ----------------------------------------------------------------------------
// nnsl_pkg
// Shared constants, codes and controller/datapath interface types for the
// nearest node snap lookup.
// ----------------------------------------------------------------------------
package nnsl_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int MAX_IDS_DEF    = 256;
   localparam int FRAC_BITS      = 8;

   localparam int COORD_W  = 24;
   localparam int ID_W     = 8;
   localparam int TAG_W    = 16;
   localparam int RADIUS_W = 23;
   localparam int MAG_W    = 24;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int DIST_W   = SQ_W + 1;
   localparam int R2_W     = 2 * RADIUS_W;
   localparam int PT_W     = 2 * COORD_W + ID_W;
   localparam int OWN_W    = ID_W + 1;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // half a unit in fixed point
   localparam logic [RADIUS_W-1:0] SNAP_RESET = RADIUS_W'((1 << FRAC_BITS) >> 1);

   // register index, taken from the word address bits of the csr port
   localparam logic [CSR_AW-3:0] CSR_IDX_RADIUS = '0;

   typedef enum logic [1:0] {
      REQ_CLEAR       = 2'd0,
      REQ_LOAD_NODE   = 2'd1,
      REQ_LOAD_MEMBER = 2'd2,
      REQ_QUERY       = 2'd3
   } nnsl_req_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_MATCH = 2'd1,
      STS_MISS  = 2'd2,
      STS_ERROR = 2'd3
   } nnsl_status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_LOAD,
      ST_MEMBER_RD,
      ST_MEMBER_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_LOOKUP,
      ST_RESPOND
   } nnsl_state_type;

   typedef struct packed {
      logic capture;
      logic idx_clear;
      logic idx_inc;
      logic count_clear;
      logic pt_write;
      logic own_sweep;
      logic own_member_rd;
      logic own_member_wr;
      logic scan_issue;
      logic own_lookup_rd;
      logic rsp_load;
   } nnsl_cmd_type;

   typedef struct packed {
      logic err;
      logic owner_hit;
      logic count_zero;
      logic last_pt;
      logic last_id;
      logic pipe_busy;
      logic rsp_free;
   } nnsl_stat_type;

endpackage

// ----- hw/rtl/nearest_node_snap_lookup.sv -----
// ----------------------------------------------------------------------------
// nearest_node_snap_lookup
// Point table with nearest-point query under a snap radius, plus a node to
// group ownership map; controller, datapath and radius register.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A query scans the stored points one
// per cycle through the point memory read port. A membership load reads then
// writes the owner memory, and a clear sweeps the owner memory one entry per
// cycle. After reset the same sweep runs before the first request is taken;
// the radius register can be written meanwhile. A new request is accepted
// while the previous result still waits on the result channel.
module nearest_node_snap_lookup
   import nnsl_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int MAX_IDS    = MAX_IDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic [ID_W-1:0]           req_node_ident,
   input  logic [ID_W-1:0]           req_group_ident,
   input  logic [TAG_W-1:0]          req_pin_tag,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [TAG_W-1:0]          rsp_tag_out,
   output logic [ID_W-1:0]           rsp_matched_node,
   output logic [ID_W-1:0]           rsp_matched_group,
   output logic                      rsp_group_found,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_AW-1:0]         csr_paddr,
   input  logic [CSR_DW-1:0]         csr_pwdata,
   output logic [CSR_DW-1:0]         csr_prdata,
   output logic                      csr_pready
);

   nnsl_cmd_type         cmd;
   nnsl_stat_type        stat;
   logic [RADIUS_W-1:0]  radius_ff;
   logic                 radius_sel;

   assign csr_pready = 1'b1;
   assign radius_sel = csr_paddr[CSR_AW-1:2] == CSR_IDX_RADIUS;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= SNAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && radius_sel) begin
         radius_ff <= csr_pwdata[RADIUS_W-1:0];
      end
   end

   assign csr_prdata = radius_sel ? CSR_DW'(radius_ff) : '0;

   nnsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nnsl_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_IDS    (MAX_IDS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_node_ident    (req_node_ident),
      .req_group_ident   (req_group_ident),
      .req_pin_tag       (req_pin_tag),
      .radius            (radius_ff),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_tag_out       (rsp_tag_out),
      .rsp_matched_node  (rsp_matched_node),
      .rsp_matched_group (rsp_matched_group),
      .rsp_group_found   (rsp_group_found)
   );

endmodule

// ----- hw/rtl/nnsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnsl_ctrl
// Sequencer for the snap lookup: request decode, table sweeps, point scan,
// group lookup and result hand-off.
// ----------------------------------------------------------------------------
module nnsl_ctrl
   import nnsl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_type,
   output logic          req_ready,
   input  nnsl_stat_type stat,
   output nnsl_cmd_type  cmd
);

   nnsl_state_type state_ff, state_in;
   nnsl_req_type   req_kind;

   assign req_kind = nnsl_req_type'(req_type);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (stat.last_id) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  REQ_CLEAR:       state_in = ST_SWEEP;
                  REQ_LOAD_NODE:   state_in = ST_LOAD;
                  REQ_LOAD_MEMBER: state_in = ST_MEMBER_RD;
                  REQ_QUERY:       state_in = stat.count_zero ? ST_RESPOND : ST_SCAN;
               endcase
            end
         end
         ST_SWEEP: begin
            if (stat.last_id) state_in = ST_RESPOND;
         end
         ST_LOAD:      state_in = ST_RESPOND;
         ST_MEMBER_RD: state_in = ST_MEMBER_WR;
         ST_MEMBER_WR: state_in = ST_RESPOND;
         ST_SCAN: begin
            if (stat.last_pt) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_LOOKUP;
         end
         ST_LOOKUP:    state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_SWEEP: begin
            cmd.own_sweep = 1'b1;
            cmd.idx_inc   = 1'b1;
         end
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.capture     = req_valid;
            cmd.idx_clear   = req_valid;
            cmd.count_clear = req_valid && (req_kind == REQ_CLEAR);
         end
         ST_LOAD: begin
            cmd.pt_write = !stat.err;
         end
         ST_MEMBER_RD: begin
            cmd.own_member_rd = 1'b1;
         end
         ST_MEMBER_WR: begin
            // first membership wins
            cmd.own_member_wr = !stat.err && !stat.owner_hit;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.idx_inc    = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_LOOKUP: begin
            cmd.own_lookup_rd = 1'b1;
         end
         ST_RESPOND: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/nnsl_dpath.sv -----
// ----------------------------------------------------------------------------
// nnsl_dpath
// Point and owner memories, distance pipeline, best-match tracking and the
// result register of the snap lookup.
// ----------------------------------------------------------------------------
module nnsl_dpath
   import nnsl_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int MAX_IDS    = MAX_IDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_type,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic [ID_W-1:0]           req_node_ident,
   input  logic [ID_W-1:0]           req_group_ident,
   input  logic [TAG_W-1:0]          req_pin_tag,
   input  logic [RADIUS_W-1:0]       radius,
   input  nnsl_cmd_type              cmd,
   output nnsl_stat_type             stat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [TAG_W-1:0]          rsp_tag_out,
   output logic [ID_W-1:0]           rsp_matched_node,
   output logic [ID_W-1:0]           rsp_matched_group,
   output logic                      rsp_group_found
);

   localparam int PT_AW = $clog2(MAX_POINTS);
   localparam int ID_AW = $clog2(MAX_IDS);
   localparam int CNT_W = PT_AW + 1;
   localparam int IDX_W = (PT_AW > ID_AW) ? PT_AW : ID_AW;
   localparam int CMP_W = IDX_W + 1;

   // captured request
   nnsl_req_type              kind_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [ID_W-1:0]           node_ff, group_ff;
   logic [TAG_W-1:0]          tag_ff;
   logic                      err_ff, err_in;

   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;

   logic [PT_W-1:0]  pt_mem [MAX_POINTS];
   logic [OWN_W-1:0] own_mem [MAX_IDS];
   logic [PT_W-1:0]  pt_rd_ff;
   logic [OWN_W-1:0] own_rd_ff;

   logic             own_wr_en, own_rd_en;
   logic [ID_AW-1:0] own_wr_addr, own_rd_addr;
   logic [OWN_W-1:0] own_wr_data;

   // scan pipeline
   logic                v0_ff, v1_ff, v2_ff;
   logic [MAG_W-1:0]    dx_ff, dy_ff;
   logic [ID_W-1:0]     id1_ff, id2_ff;
   logic [SQ_W-1:0]     dx2_ff, dy2_ff;
   logic [COORD_W:0]    dx_diff, dy_diff, dx_neg, dy_neg;
   logic [MAG_W-1:0]    dx_mag, dy_mag;
   logic [DIST_W-1:0]   d2;
   logic                have_ff;
   logic [DIST_W-1:0]   best_ff;
   logic [ID_W-1:0]     best_id_ff;
   logic [R2_W-1:0]     r2_ff;

   logic                node_bad, group_bad, table_full;

   assign node_bad   = 32'(req_node_ident) >= 32'(MAX_IDS);
   assign group_bad  = 32'(req_group_ident) >= 32'(MAX_IDS);
   assign table_full = count_ff == CNT_W'(MAX_POINTS);

   always_comb begin
      case (nnsl_req_type'(req_type))
         REQ_LOAD_NODE:   err_in = table_full || node_bad;
         REQ_LOAD_MEMBER: err_in = node_bad || group_bad;
         default:         err_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= nnsl_req_type'(req_type);
         x_ff     <= req_coord_x;
         y_ff     <= req_coord_y;
         node_ff  <= req_node_ident;
         group_ff <= req_group_ident;
         tag_ff   <= req_pin_tag;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.count_clear) begin
            count_ff <= '0;
         end else if (cmd.pt_write) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // point memory
   always_ff @(posedge clock) begin
      if (cmd.pt_write) begin
         pt_mem[count_ff[PT_AW-1:0]] <= {x_ff, y_ff, node_ff};
      end
      if (cmd.scan_issue) begin
         pt_rd_ff <= pt_mem[idx_ff[PT_AW-1:0]];
      end
   end

   // owner memory: {valid, group}, cleared by sweeping
   assign own_wr_en   = cmd.own_sweep || cmd.own_member_wr;
   assign own_wr_addr = cmd.own_sweep ? idx_ff[ID_AW-1:0] : ID_AW'(node_ff);
   assign own_wr_data = cmd.own_sweep ? '0 : {1'b1, group_ff};
   assign own_rd_en   = cmd.own_member_rd || cmd.own_lookup_rd;
   assign own_rd_addr = cmd.own_member_rd ? ID_AW'(node_ff) : ID_AW'(best_id_ff);

   always_ff @(posedge clock) begin
      if (own_wr_en) begin
         own_mem[own_wr_addr] <= own_wr_data;
      end
      if (own_rd_en) begin
         own_rd_ff <= own_mem[own_rd_addr];
      end
   end

   // distance: |dx|, |dy| then squares then sum and compare
   always_comb begin
      dx_diff = {pt_rd_ff[PT_W-1], pt_rd_ff[PT_W-1 -: COORD_W]} - {x_ff[COORD_W-1], x_ff};
      dy_diff = {pt_rd_ff[ID_W+COORD_W-1], pt_rd_ff[ID_W +: COORD_W]} - {y_ff[COORD_W-1], y_ff};
      dx_neg  = ~dx_diff + 1'b1;
      dy_neg  = ~dy_diff + 1'b1;
      dx_mag  = dx_diff[COORD_W] ? dx_neg[MAG_W-1:0] : dx_diff[MAG_W-1:0];
      dy_mag  = dy_diff[COORD_W] ? dy_neg[MAG_W-1:0] : dy_diff[MAG_W-1:0];
      d2      = DIST_W'(dx2_ff) + DIST_W'(dy2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.scan_issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_mag;
      dy_ff  <= dy_mag;
      id1_ff <= pt_rd_ff[ID_W-1:0];
      dx2_ff <= dx_ff * dx_ff;
      dy2_ff <= dy_ff * dy_ff;
      id2_ff <= id1_ff;
      r2_ff  <= radius * radius;
   end

   // strict less-than keeps the earliest point on a tie
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         have_ff <= 1'b0;
      end else if (v2_ff && (!have_ff || d2 < best_ff)) begin
         have_ff    <= 1'b1;
         best_ff    <= d2;
         best_id_ff <= id2_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_tag_out       <= tag_ff;
         rsp_status        <= STS_DONE;
         rsp_matched_node  <= '0;
         rsp_matched_group <= '0;
         rsp_group_found   <= 1'b0;
         case (kind_ff) inside
            REQ_QUERY: begin
               if (!have_ff || best_ff > DIST_W'(r2_ff)) begin
                  rsp_status <= STS_MISS;
               end else begin
                  rsp_status       <= STS_MATCH;
                  rsp_matched_node <= best_id_ff;
                  rsp_group_found  <= own_rd_ff[ID_W];
                  if (own_rd_ff[ID_W]) begin
                     rsp_matched_group <= own_rd_ff[ID_W-1:0];
                  end
               end
            end
            REQ_LOAD_NODE, REQ_LOAD_MEMBER: begin
               if (err_ff) rsp_status <= STS_ERROR;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stat.err        = err_ff;
      stat.owner_hit  = own_rd_ff[ID_W];
      stat.count_zero = count_ff == '0;
      stat.last_pt    = (CMP_W'(idx_ff) + CMP_W'(1)) == CMP_W'(count_ff);
      stat.last_id    = idx_ff == IDX_W'(MAX_IDS - 1);
      stat.pipe_busy  = v0_ff || v1_ff || v2_ff;
      stat.rsp_free   = !rsp_valid || rsp_ready;
   end

   a_pt_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pt_write |-> count_ff < CNT_W'(MAX_POINTS))
      else $error("point written into a full table");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> CMP_W'(idx_ff) < CMP_W'(count_ff))
      else $error("scan read beyond loaded points");

   a_lookup_settled: assert property (@(posedge clock) disable iff (reset)
      cmd.own_lookup_rd |-> (!v0_ff && !v1_ff && !v2_ff && have_ff))
      else $error("group lookup before best match settled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.rsp_load)
      else $error("pending result overwritten");

endmodule
